// File: sv/nvs_pkg.sv
// shared constants and types for the nearest vector search block
package nvs_pkg;

  // sizes of the datapath
  localparam int MAX_DIMS   = 1024;
  localparam int ELEM_BITS  = 16;
  localparam int INDEX_BITS = 16;
  localparam int DIST_BITS  = 42;
  localparam int DIMS_BITS  = 11;
  localparam int CNT_BITS   = $clog2(MAX_DIMS);
  localparam int DIFF_BITS  = ELEM_BITS + 1;
  localparam int SQ_BITS    = 2 * ELEM_BITS;

  // configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_VECTOR_DIMS = 1'b0;

  localparam logic [DIMS_BITS-1:0]  DIMS_RESET = DIMS_BITS'(128);
  localparam logic [DIMS_BITS-1:0]  DIMS_LIMIT = DIMS_BITS'(MAX_DIMS);
  localparam logic [DIST_BITS-1:0]  DIST_MAX   = {DIST_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0] INDEX_MAX  = {INDEX_BITS{1'b1}};

  // stream widths
  localparam int IN_DATA_BITS  = 2 * ELEM_BITS;
  localparam int OUT_RAW_BITS  = INDEX_BITS + DIST_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  // squared difference passed to the accumulator
  typedef struct packed {
    logic [SQ_BITS-1:0] sq;
    logic               last;
  } sq_item_t;

  // one search result
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [DIST_BITS-1:0]  distance;
  } result_t;

endpackage

// File: sv/nvs_sq_stage.sv
// input register and squared difference register
module nvs_sq_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [nvs_pkg::ELEM_BITS-1:0]   query_elem_i,
  input  logic [nvs_pkg::ELEM_BITS-1:0]   cand_elem_i,
  input  logic                            last_of_list_i,
  output logic                            sq_valid_o,
  output nvs_pkg::sq_item_t               sq_o,
  input  logic                            sq_ready_i
);

  logic                          in_valid_q, in_valid_d;
  logic [nvs_pkg::ELEM_BITS-1:0] query_q, cand_q;
  logic                          last_q;
  logic                          sq_valid_q, sq_valid_d;
  nvs_pkg::sq_item_t             sq_q, sq_d;
  logic                          sq_advance;
  logic                          in_advance;
  logic [nvs_pkg::DIFF_BITS-1:0] diff;
  logic [nvs_pkg::DIFF_BITS-1:0] diff_neg;
  logic [nvs_pkg::ELEM_BITS-1:0] mag;

  // stage handshakes
  assign sq_advance = !sq_valid_q || sq_ready_i;
  assign in_advance = !in_valid_q || sq_advance;
  assign ready_o    = in_advance;

  // signed difference and its magnitude
  always_comb begin
    diff     = {query_q[nvs_pkg::ELEM_BITS-1], query_q}
             - {cand_q[nvs_pkg::ELEM_BITS-1], cand_q};
    diff_neg = ~diff + nvs_pkg::DIFF_BITS'(1);
    mag      = diff[nvs_pkg::DIFF_BITS-1] ? diff_neg[nvs_pkg::ELEM_BITS-1:0]
                                          : diff[nvs_pkg::ELEM_BITS-1:0];
    sq_d.sq   = mag * mag;
    sq_d.last = last_q;
  end

  assign in_valid_d = in_advance ? valid_i : in_valid_q;
  assign sq_valid_d = sq_advance ? in_valid_q : sq_valid_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sq_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      sq_valid_q <= sq_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (valid_i && in_advance) begin
      query_q <= query_elem_i;
      cand_q  <= cand_elem_i;
      last_q  <= last_of_list_i;
    end
    if (in_valid_q && sq_advance) begin
      sq_q <= sq_d;
    end
  end

  assign sq_valid_o = sq_valid_q;
  assign sq_o       = sq_q;

endmodule

// File: sv/nvs_accum.sv
// distance accumulator, best candidate tracking and result register
module nvs_accum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [nvs_pkg::DIMS_BITS-1:0]   dims_i,
  input  logic                            sq_valid_i,
  input  nvs_pkg::sq_item_t               sq_i,
  output logic                            sq_ready_o,
  output logic                            res_valid_o,
  output nvs_pkg::result_t                res_o,
  input  logic                            res_ready_i
);

  logic [nvs_pkg::DIST_BITS-1:0]  running_q, running_d;
  logic [nvs_pkg::CNT_BITS-1:0]   elem_cnt_q, elem_cnt_d;
  logic [nvs_pkg::INDEX_BITS-1:0] cand_cnt_q, cand_cnt_d;
  logic [nvs_pkg::DIST_BITS-1:0]  closest_q, closest_d;
  logic [nvs_pkg::INDEX_BITS-1:0] closest_idx_q, closest_idx_d;
  logic                           res_valid_q, res_valid_d;
  nvs_pkg::result_t               res_q;
  logic                           take;
  logic [nvs_pkg::DIST_BITS:0]    sum_full;
  logic [nvs_pkg::DIST_BITS-1:0]  sum;
  logic [nvs_pkg::DIMS_BITS-1:0]  cnt_next;
  logic                           cand_done;
  logic [nvs_pkg::DIST_BITS-1:0]  best_sum;
  logic [nvs_pkg::INDEX_BITS-1:0] best_idx;

  // stall only a final item that finds the result register still full
  assign sq_ready_o = !(sq_valid_i && sq_i.last && res_valid_q && !res_ready_i);
  assign take       = sq_valid_i && sq_ready_o;

  // saturating accumulate and candidate close
  always_comb begin
    sum_full  = {1'b0, running_q} + (nvs_pkg::DIST_BITS + 1)'(sq_i.sq);
    sum       = sum_full[nvs_pkg::DIST_BITS] ? nvs_pkg::DIST_MAX
                                             : sum_full[nvs_pkg::DIST_BITS-1:0];
    cnt_next  = {1'b0, elem_cnt_q} + nvs_pkg::DIMS_BITS'(1);
    cand_done = (cnt_next >= dims_i) || sq_i.last;

    // later candidate wins a tie
    if (cand_done && (sum <= closest_q)) begin
      best_sum = sum;
      best_idx = cand_cnt_q;
    end else begin
      best_sum = closest_q;
      best_idx = closest_idx_q;
    end

    running_d     = running_q;
    elem_cnt_d    = elem_cnt_q;
    cand_cnt_d    = cand_cnt_q;
    closest_d     = closest_q;
    closest_idx_d = closest_idx_q;
    if (take) begin
      closest_d     = best_sum;
      closest_idx_d = best_idx;
      if (cand_done) begin
        running_d  = '0;
        elem_cnt_d = '0;
        if (cand_cnt_q != nvs_pkg::INDEX_MAX) begin
          cand_cnt_d = cand_cnt_q + nvs_pkg::INDEX_BITS'(1);
        end
      end else begin
        running_d  = sum;
        elem_cnt_d = cnt_next[nvs_pkg::CNT_BITS-1:0];
      end
      // end of query clears the search
      if (sq_i.last) begin
        cand_cnt_d    = '0;
        closest_d     = nvs_pkg::DIST_MAX;
        closest_idx_d = '0;
      end
    end

    if (take && sq_i.last) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= '0;
      elem_cnt_q    <= '0;
      cand_cnt_q    <= '0;
      closest_q     <= nvs_pkg::DIST_MAX;
      closest_idx_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      running_q     <= running_d;
      elem_cnt_q    <= elem_cnt_d;
      cand_cnt_q    <= cand_cnt_d;
      closest_q     <= closest_d;
      closest_idx_q <= closest_idx_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take && sq_i.last) begin
      res_q.index    <= best_idx;
      res_q.distance <= best_sum;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/nearest_vector_search.sv
// top level: configuration register, square stage and accumulator
// a result leaves after its final element passes the input, square and result registers
// throughput: one element pair per cycle, set by the accumulate loop
// a second final element stalls only while an earlier result is still untaken
// reset: vector_dims returns to 128, sums and counts clear, best distance all ones
// no clearing pass after reset; input is taken in the first cycle
module nearest_vector_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nvs_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [nvs_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [nvs_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // element pair stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] query_elem, [31:16] cand_elem
  input  logic [nvs_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // last_of_list
  input  logic                                s_axis_tlast,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] best_index, [57:16] best_distance, [63:58] zero
  output logic [nvs_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

  logic [nvs_pkg::DIMS_BITS-1:0] dims_q;
  logic [nvs_pkg::DIMS_BITS-1:0] dims_eff;
  logic                          reg_sel;
  logic                          sq_valid;
  logic                          sq_ready;
  nvs_pkg::sq_item_t             sq_item;
  nvs_pkg::result_t              res;

  // register decode
  assign reg_sel = (paddr[nvs_pkg::APB_ADDR_BITS-1] == nvs_pkg::REG_VECTOR_DIMS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? nvs_pkg::APB_DATA_BITS'(dims_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= nvs_pkg::DIMS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      dims_q <= pwdata[nvs_pkg::DIMS_BITS-1:0];
    end
  end

  // zero means one, above the limit means the limit
  always_comb begin
    if (dims_q == '0) begin
      dims_eff = nvs_pkg::DIMS_BITS'(1);
    end else if (dims_q > nvs_pkg::DIMS_LIMIT) begin
      dims_eff = nvs_pkg::DIMS_LIMIT;
    end else begin
      dims_eff = dims_q;
    end
  end

  nvs_sq_stage u_sq_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .query_elem_i   (s_axis_tdata[nvs_pkg::ELEM_BITS-1:0]),
    .cand_elem_i    (s_axis_tdata[2*nvs_pkg::ELEM_BITS-1:nvs_pkg::ELEM_BITS]),
    .last_of_list_i (s_axis_tlast),
    .sq_valid_o     (sq_valid),
    .sq_o           (sq_item),
    .sq_ready_i     (sq_ready)
  );

  nvs_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims_eff),
    .sq_valid_i  (sq_valid),
    .sq_i        (sq_item),
    .sq_ready_o  (sq_ready),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  // pack result, index in the low bits
  assign m_axis_tdata = nvs_pkg::OUT_DATA_BITS'({res.distance, res.index});

endmodule

// File: tb/tb.sv
// self-checking testbench for the nearest vector search block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [nvs_pkg::APB_ADDR_BITS-1:0] DIMS_ADDR =
    nvs_pkg::APB_ADDR_BITS'(4 * int'(nvs_pkg::REG_VECTOR_DIMS));

  // tracks the closest candidate per query and holds the results still owed
  class nearest_finder;
    logic [nvs_pkg::DIMS_BITS-1:0] dims_reg;
    longint unsigned               cand_sum;
    int unsigned                   elems_taken;
    longint unsigned               cand_index;
    longint unsigned               best_sum;
    longint unsigned               best_index;
    nvs_pkg::result_t              pending_matches[$];
    int unsigned                   mismatches;

    function new();
      dims_reg    = nvs_pkg::DIMS_RESET;
      mismatches  = 0;
      clear_query();
    endfunction

    function void clear_query();
      cand_sum    = 0;
      elems_taken = 0;
      cand_index  = 0;
      best_sum    = 64'(nvs_pkg::DIST_MAX);
      best_index  = 0;
    endfunction

    function void set_dims(logic [nvs_pkg::DIMS_BITS-1:0] value);
      dims_reg = value;
    endfunction

    // one accepted element pair
    function void take_pair(logic signed [nvs_pkg::ELEM_BITS-1:0] q,
                            logic signed [nvs_pkg::ELEM_BITS-1:0] c, logic last);
      longint           diff;
      longint unsigned  sq_val;
      longint unsigned  vec_len;
      nvs_pkg::result_t match;
      diff   = longint'(q) - longint'(c);
      if (diff < 0) diff = -diff;
      sq_val = longint'(diff) * longint'(diff);
      // accumulate with saturation at the distance maximum
      if (sq_val > 64'(nvs_pkg::DIST_MAX) - cand_sum) cand_sum = 64'(nvs_pkg::DIST_MAX);
      else cand_sum = cand_sum + sq_val;
      elems_taken++;
      // zero counts as one, oversize clamps to the maximum
      vec_len = (dims_reg == 0) ? 1 :
                (dims_reg > nvs_pkg::MAX_DIMS) ? nvs_pkg::MAX_DIMS : dims_reg;
      if (elems_taken >= vec_len || last) begin
        // ties go to the later candidate
        if (cand_sum <= best_sum) begin
          best_sum   = cand_sum;
          best_index = cand_index;
        end
        if (cand_index < 64'(nvs_pkg::INDEX_MAX)) cand_index++;
        cand_sum    = 0;
        elems_taken = 0;
      end
      if (last) begin
        match.index    = best_index[nvs_pkg::INDEX_BITS-1:0];
        match.distance = best_sum[nvs_pkg::DIST_BITS-1:0];
        pending_matches.push_back(match);
        clear_query();
      end
    endfunction

    // one accepted result transfer
    function void check_match(logic [nvs_pkg::OUT_DATA_BITS-1:0] data);
      nvs_pkg::result_t want;
      if (pending_matches.size() == 0) begin
        $error("result with no expectation waiting: best_index %0d best_distance %0d",
               data[nvs_pkg::INDEX_BITS-1:0],
               data[nvs_pkg::INDEX_BITS +: nvs_pkg::DIST_BITS]);
        mismatches++;
        return;
      end
      want = pending_matches.pop_front();
      if (data[nvs_pkg::INDEX_BITS-1:0] !== want.index) begin
        $error("best_index expected %0d actual %0d", want.index,
               data[nvs_pkg::INDEX_BITS-1:0]);
        mismatches++;
      end
      if (data[nvs_pkg::INDEX_BITS +: nvs_pkg::DIST_BITS] !== want.distance) begin
        $error("best_distance expected %0d actual %0d", want.distance,
               data[nvs_pkg::INDEX_BITS +: nvs_pkg::DIST_BITS]);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [nvs_pkg::APB_ADDR_BITS-1:0]   paddr = '0;
  logic [nvs_pkg::APB_DATA_BITS-1:0]   pwdata = '0;
  logic [nvs_pkg::APB_DATA_BITS-1:0]   prdata;
  logic                                pready;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  // [15:0] query_elem, [31:16] cand_elem
  logic [nvs_pkg::IN_DATA_BITS-1:0]    s_axis_tdata = '0;
  // last_of_list
  logic                                s_axis_tlast = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  // [15:0] best_index, [57:16] best_distance, [63:58] zero
  logic [nvs_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;

  nearest_finder finder = new();
  bit            idle_on = 1'b1;
  int unsigned   quiet_cycles = 0;

  nearest_vector_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // handshakes are sampled mid-cycle, where inputs and outputs are settled
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) finder.check_match(m_axis_tdata);
    if (rst_ni && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[nearest_vector_search] ERROR");
      $finish;
    end
  end

  // result side backpressure in random bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // element value with the extremes favored
  function automatic logic signed [nvs_pkg::ELEM_BITS-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // one element pair transfer, optionally after a gap
  task automatic send_pair(input logic signed [nvs_pkg::ELEM_BITS-1:0] q,
                           input logic signed [nvs_pkg::ELEM_BITS-1:0] c,
                           input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, q};
    s_axis_tlast  <= last;
    do @(negedge clk_i); while (!s_axis_tready);
    finder.take_pair(q, c, last);
    @(posedge clk_i);
  endtask

  // drain all results and let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (finder.pending_matches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_dims(input logic [nvs_pkg::DIMS_BITS-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= DIMS_ADDR;
    pwdata  <= nvs_pkg::APB_DATA_BITS'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    finder.set_dims(value);
  endtask

  // one query: several candidates, sometimes ended early
  task automatic send_query(input int unsigned vec_len, input int unsigned n_cands);
    logic signed [nvs_pkg::ELEM_BITS-1:0] qv[];
    logic signed [nvs_pkg::ELEM_BITS-1:0] cv;
    int unsigned                          cut;
    int unsigned                          mode;
    int unsigned                          span;
    qv = new[vec_len];
    foreach (qv[k]) qv[k] = pick_elem();
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, vec_len) : vec_len;
    for (int n = 0; n < n_cands; n++) begin
      mode = $urandom_range(0, 2);
      span = (n == n_cands - 1) ? cut : vec_len;
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: cv = pick_elem();
          1: cv = qv[k] + $signed(16'($urandom_range(0, 4))) - 16'sd2;
          default: cv = qv[k];
        endcase
        send_pair(qv[k], cv, (n == n_cands - 1) && (k == span - 1));
      end
    end
  endtask

  initial begin
    int unsigned                   pairs_left;
    int unsigned                   vec_len;
    logic [nvs_pkg::DIMS_BITS-1:0] dims_val;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties, early last
    write_dims(11'd4);
    repeat (4) send_pair(16'sh7fff, 16'sh8000, 1'b0);
    repeat (4) send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    repeat (4) send_pair(16'sd100, 16'sd90, 1'b0);
    send_pair(16'sd5, 16'sd0, 1'b1);
    send_pair(16'sd7, -16'sd7, 1'b1);
    settle();
    // dimension zero acts as one
    write_dims(11'd0);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd3, 16'sd1, 1'b1);
    settle();
    write_dims(11'd1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    settle();

    // dimension changed in the middle of a candidate, shrink then grow
    write_dims(11'd8);
    repeat (5) send_pair(pick_elem(), pick_elem(), 1'b0);
    settle();
    write_dims(11'd3);
    repeat (3) send_pair(pick_elem(), pick_elem(), 1'b0);
    send_pair(pick_elem(), pick_elem(), 1'b1);
    settle();
    write_dims(11'd2);
    send_pair(pick_elem(), pick_elem(), 1'b0);
    settle();
    write_dims(11'd6);
    repeat (4) send_pair(pick_elem(), pick_elem(), 1'b0);
    send_pair(pick_elem(), pick_elem(), 1'b1);
    settle();

    // largest dimension, exact and clamped, ended early
    write_dims(11'd1024);
    repeat (9) send_pair(pick_elem(), pick_elem(), 1'b0);
    send_pair(pick_elem(), pick_elem(), 1'b1);
    settle();
    write_dims(11'd2047);
    repeat (5) send_pair(pick_elem(), pick_elem(), 1'b0);
    send_pair(pick_elem(), pick_elem(), 1'b1);
    settle();

    // random queries over several dimensions, no idling in the last phases
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: dims_val = 11'd1;
        1: dims_val = 11'd0;
        2: dims_val = 11'($urandom_range(2, 5));
        3: dims_val = 11'($urandom_range(6, 16));
        default: dims_val = 11'($urandom_range(1, 9));
      endcase
      if (phase >= 4) idle_on = 1'b0;
      write_dims(dims_val);
      vec_len = (dims_val == 0) ? 1 : dims_val;
      pairs_left = 90;
      while (pairs_left > 0) begin
        send_query(vec_len, $urandom_range(1, 6));
        pairs_left = (pairs_left > 3 * vec_len) ? pairs_left - 3 * vec_len : 0;
      end
      settle();
    end

    if (finder.mismatches == 0) begin
      $display("[nearest_vector_search] OK");
    end else begin
      $display("[nearest_vector_search] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/nvs_pkg.sv
sv/nvs_sq_stage.sv
sv/nvs_accum.sv
sv/nearest_vector_search.sv
tb/tb.sv
